/* rtl/scan_device_table_defines.svh */
// ----------------------------------------------------------------------------
// scan_device_table_defines
// Assertion macros used by the device table datapath.
// ----------------------------------------------------------------------------
`ifndef SCAN_DEVICE_TABLE_DEFINES_SVH
`define SCAN_DEVICE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sdt_pkg.sv */
// ----------------------------------------------------------------------------
// sdt_pkg
// Types, codes and helpers for the scan device table.
// ----------------------------------------------------------------------------
package sdt_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_CREATE = 3'd0,
        EV_UPDATE = 3'd1,
        EV_DELETE = 3'd2,
        EV_HIT    = 3'd3,
        EV_MISS   = 3'd4,
        EV_LIST   = 3'd5,
        EV_EMPTY  = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT,
        ST_MISS,
        ST_CLR_RD,
        ST_CLR_OUT,
        ST_LIST_RD,
        ST_LIST_OUT
    } t_state;

    localparam int ADDR_BITS = 48;
    localparam int TYPE_BITS = 2;
    localparam int STR_BITS  = 8;
    localparam int NAME_BITS = 56;
    localparam int NAME_MAX  = 7;

    typedef struct packed {
        logic [1:0]                 op;
        logic [ADDR_BITS-1:0]       dev_addr;
        logic [TYPE_BITS-1:0]       dev_addr_type;
        logic signed [STR_BITS-1:0] signal_strength;
        logic                       name_given;
        logic [NAME_BITS-1:0]       dev_name;
    } t_sdt_in;

    typedef struct packed {
        logic [2:0]                 event_res;
        logic [ADDR_BITS-1:0]       out_addr;
        logic [TYPE_BITS-1:0]       out_addr_type;
        logic signed [STR_BITS-1:0] out_strength;
        logic [NAME_BITS-1:0]       out_name;
        logic [3:0]                 entry_index;
        logic [4:0]                 entry_count;
        logic                       last;
    } t_sdt_out;

    typedef struct packed {
        logic   load;     // capture the input item, restart the scan
        logic   rd_en;    // read one table entry
        logic   rd_top;   // read the highest used entry instead of the scan index
        logic   emit;     // transfer a result into the output register
        t_event ev;
    } t_sdt_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       match;
        logic       idx_end;
        logic       chk;
        logic       full;
        logic       empty;
        logic       out_free;
    } t_sdt_status;

    // Keep bytes up to the first zero byte, at most nchars of them
    function automatic logic [NAME_BITS-1:0] clip_name(input logic [NAME_BITS-1:0] raw,
                                                       input int unsigned nchars);
        logic [NAME_BITS-1:0] kept;
        logic                 alive;
        kept  = '0;
        alive = 1'b1;
        for (int b = 0; b < NAME_MAX; b++) begin
            if (b >= nchars || raw[8*b +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                kept[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

/* rtl/sdt_ram.sv */
// ----------------------------------------------------------------------------
// sdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sdt_ctrl.sv */
// ----------------------------------------------------------------------------
// sdt_ctrl
// Operation sequencer: scans, updates, clears and lists the table.
// ----------------------------------------------------------------------------
module sdt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_op,
    input  sdt_pkg::t_sdt_status i_st,
    output logic                o_stall,
    output sdt_pkg::t_sdt_cmd   o_cmd
);
    import sdt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_stall       = 1'b1;
        o_cmd         = '0;
        o_cmd.ev      = EV_CREATE;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OP_ADD, OP_LOOKUP: n_state = ST_SEARCH;
                        OP_CLEAR:          n_state = ST_CLR_RD;
                        OP_LIST:           n_state = ST_LIST_RD;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH: begin
                // one read per cycle, compare in the cycle after the read
                if (i_st.match) begin
                    n_state = ST_HIT;
                end else if (!i_st.idx_end) begin
                    o_cmd.rd_en = 1'b1;
                end else if (!i_st.chk) begin
                    n_state = ST_MISS;
                end
            end
            ST_HIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = (i_st.op == OP_ADD) ? EV_UPDATE : EV_HIT;
                    n_state    = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (i_st.op == OP_ADD && i_st.full) begin
                    n_state = ST_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = (i_st.op == OP_ADD) ? EV_CREATE : EV_MISS;
                    n_state    = ST_IDLE;
                end
            end
            ST_CLR_RD: begin
                if (i_st.empty) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_top = 1'b1;
                    n_state      = ST_CLR_OUT;
                end
            end
            ST_CLR_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = EV_DELETE;
                    n_state    = ST_CLR_RD;
                end
            end
            ST_LIST_RD: begin
                if (i_st.empty) begin
                    if (i_st.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.ev   = EV_EMPTY;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_LIST_OUT;
                end
            end
            ST_LIST_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = EV_LIST;
                    n_state    = i_st.idx_end ? ST_IDLE : ST_LIST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sdt_datapath.sv */
// ----------------------------------------------------------------------------
// sdt_datapath
// Item register, entry RAM, scan counters, fill count and result register.
// ----------------------------------------------------------------------------
`include "scan_device_table_defines.svh"

module sdt_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int NAME_CHARS  = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdt_pkg::t_sdt_in     i_in,
    input  sdt_pkg::t_sdt_cmd    i_cmd,
    input  logic                 i_stall,
    output sdt_pkg::t_sdt_status o_st,
    output logic                 o_valid,
    output sdt_pkg::t_sdt_out    o_out
);
    import sdt_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int NAME_W = 8 * NAME_CHARS;
    localparam int STR_LO = ADDR_BITS + TYPE_BITS;
    localparam int NAM_LO = STR_LO + STR_BITS;
    localparam int ENT_W  = NAM_LO + NAME_W;

    t_sdt_in          r_item;
    logic [NAME_W-1:0] r_name;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_used;
    logic             r_chk;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_out_valid;
    t_sdt_out         r_out;

    logic [ENT_W-1:0] w_rdata;
    logic [ENT_W-1:0] w_wdata;
    logic [ENT_W-1:0] w_upd_word;
    logic [ENT_W-1:0] w_new_word;
    logic [IDX_W-1:0] w_raddr;
    logic [IDX_W-1:0] w_waddr;
    logic             w_we;
    logic [CNT_W-1:0] w_used_m1;
    logic [CNT_W-1:0] w_used_p1;
    logic [NAME_BITS-1:0] w_clip;
    logic [NAME_W-1:0] w_upd_name;
    logic [NAME_W-1:0] w_new_name;
    logic [NAME_W-1:0] w_ent_name;
    logic [ADDR_BITS-1:0] w_ent_addr;
    logic [TYPE_BITS-1:0] w_ent_type;
    logic [STR_BITS-1:0]  w_ent_str;
    logic [CNT_W-1:0] w_sel_idx;
    logic [CNT_W-1:0] w_sel_cnt;
    logic [31:0]      w_idx_ext;
    logic [31:0]      w_cnt_ext;
    logic             w_last;
    logic             w_zero_ent;
    logic             w_out_free;
    t_sdt_out         w_out;

    assign w_clip     = clip_name(i_in.dev_name, NAME_CHARS);
    assign w_used_m1  = r_used - 1'b1;
    assign w_used_p1  = r_used + 1'b1;
    assign w_out_free = !r_out_valid || !i_stall;

    // ---- entry storage ----
    assign w_raddr = i_cmd.rd_top ? w_used_m1[IDX_W-1:0] : r_idx[IDX_W-1:0];

    assign w_upd_name = r_item.name_given ? r_name : w_rdata[ENT_W-1:NAM_LO];
    assign w_new_name = r_item.name_given ? r_name : '0;
    assign w_upd_word = {w_upd_name, r_item.signal_strength, w_rdata[STR_LO-1:0]};
    assign w_new_word = {w_new_name, r_item.signal_strength,
                         r_item.dev_addr_type, r_item.dev_addr};

    assign w_we    = i_cmd.emit && (i_cmd.ev == EV_UPDATE || i_cmd.ev == EV_CREATE);
    assign w_waddr = (i_cmd.ev == EV_CREATE) ? r_used[IDX_W-1:0] : r_chk_idx;
    assign w_wdata = (i_cmd.ev == EV_CREATE) ? w_new_word : w_upd_word;

    sdt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en && !i_cmd.rd_top) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit && i_cmd.ev == EV_CREATE) begin
                r_used <= w_used_p1;
            end else if (i_cmd.emit && i_cmd.ev == EV_DELETE) begin
                r_used <= CNT_W'(r_chk_idx);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
            r_name <= w_clip[NAME_W-1:0];
        end
        if (i_cmd.rd_en) begin
            r_chk_idx <= w_raddr;
        end
        if (i_cmd.emit) begin
            r_out <= w_out;
        end
    end

    // ---- result build ----
    always_comb begin
        w_ent_addr = w_rdata[ADDR_BITS-1:0];
        w_ent_type = w_rdata[STR_LO-1:ADDR_BITS];
        w_ent_str  = w_rdata[NAM_LO-1:STR_LO];
        w_ent_name = w_rdata[ENT_W-1:NAM_LO];
        w_sel_idx  = CNT_W'(r_chk_idx);
        w_sel_cnt  = r_used;
        w_last     = 1'b1;
        w_zero_ent = 1'b0;
        case (i_cmd.ev)
            EV_CREATE: begin
                w_ent_addr = r_item.dev_addr;
                w_ent_type = r_item.dev_addr_type;
                w_ent_str  = r_item.signal_strength;
                w_ent_name = w_new_name;
                w_sel_idx  = r_used;
                w_sel_cnt  = w_used_p1;
            end
            EV_UPDATE: begin
                w_ent_str  = r_item.signal_strength;
                w_ent_name = w_upd_name;
            end
            EV_DELETE: begin
                // entries left once this one is gone
                w_sel_cnt = CNT_W'(r_chk_idx);
                w_last    = (r_chk_idx == '0);
            end
            EV_HIT: begin
            end
            EV_MISS: begin
                w_zero_ent = 1'b1;
                w_ent_addr = r_item.dev_addr;
                w_ent_type = r_item.dev_addr_type;
                w_sel_idx  = '0;
            end
            EV_LIST: begin
                w_last = (r_idx == r_used);
            end
            EV_EMPTY: begin
                w_zero_ent = 1'b1;
                w_ent_addr = '0;
                w_ent_type = '0;
                w_sel_idx  = '0;
                w_sel_cnt  = '0;
            end
            default: begin
            end
        endcase
        if (w_zero_ent) begin
            w_ent_str  = '0;
            w_ent_name = '0;
        end
        w_idx_ext           = 32'(w_sel_idx);
        w_cnt_ext           = 32'(w_sel_cnt);
        w_out.event_res     = i_cmd.ev;
        w_out.out_addr      = w_ent_addr;
        w_out.out_addr_type = w_ent_type;
        w_out.out_strength  = w_ent_str;
        w_out.out_name      = NAME_BITS'(w_ent_name);
        w_out.entry_index   = w_idx_ext[3:0];
        w_out.entry_count   = w_cnt_ext[4:0];
        w_out.last          = w_last;
    end

    // ---- status ----
    assign o_st.op       = r_item.op;
    assign o_st.match    = r_chk && w_rdata[ADDR_BITS-1:0] == r_item.dev_addr
                           && w_rdata[STR_LO-1:ADDR_BITS] == r_item.dev_addr_type;
    assign o_st.idx_end  = (r_idx == r_used);
    assign o_st.chk      = r_chk;
    assign o_st.full     = (r_used == CNT_W'(MAX_ENTRIES));
    assign o_st.empty    = (r_used == '0);
    assign o_st.out_free = w_out_free;

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // ---- checks ----
    `SDT_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(MAX_ENTRIES), "fill count above table size")
    `SDT_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, i_cmd.emit, w_out_free, "result overwrites a pending transfer")
    `SDT_ASSERT_NEXT(a_create_grow, i_clk, i_rst_n, i_cmd.emit && i_cmd.ev == EV_CREATE, r_used == $past(r_used) + 1'b1, "create did not grow the table")
    `SDT_ASSERT_NEXT(a_delete_shrink, i_clk, i_rst_n, i_cmd.emit && i_cmd.ev == EV_DELETE, r_used == $past(r_used) - 1'b1, "delete did not shrink the table")

endmodule

/* rtl/scan_device_table.sv */
// ----------------------------------------------------------------------------
// scan_device_table
// Table of seen radio devices: add/update, lookup, clear and list.
//
//   channel  | signals                    | payload
//   ---------+----------------------------+-----------
//   input    | i_valid, o_stall           | i_in  (t_sdt_in)
//   result   | o_valid, i_stall           | o_out (t_sdt_out)
//
// One item at a time; o_stall is low only while the sequencer is idle.
// Add and lookup read one entry per cycle and compare in the next cycle;
// the result is loaded after a match or at the end of the scan. Clear
// deletes the highest used entry until the table is empty; list gives one
// result per entry, or one empty result for an empty table. Reset empties
// the table at once, no clearing pass. A stalled result sits in the output
// register; the next result waits.
// ----------------------------------------------------------------------------
module scan_device_table #(
    parameter int MAX_ENTRIES = 16,
    parameter int NAME_CHARS  = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sdt_pkg::t_sdt_in  i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output sdt_pkg::t_sdt_out o_out
);
    import sdt_pkg::*;

    t_sdt_cmd    w_cmd;
    t_sdt_status w_st;

    sdt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_op   (i_in.op),
        .i_st   (w_st),
        .o_stall(o_stall),
        .o_cmd  (w_cmd)
    );

    sdt_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .NAME_CHARS (NAME_CHARS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_cmd  (w_cmd),
        .i_stall(i_stall),
        .o_st   (w_st),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

endmodule
